// File: src/i2cm_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
`default_nettype none
package i2cm_pkg;

   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned TPU_W         = 10;
   localparam int unsigned LIMIT_W       = 8;
   localparam int unsigned DELAY_W       = 13;
   localparam int unsigned BIT_W         = 4;
   localparam logic [7:0]  LIMIT_RESET   = 8'd250;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_START    = 3'd1,
      OP_STOP     = 3'd2,
      OP_WRITE    = 3'd3,
      OP_READ     = 3'd4,
      OP_WAIT_ACK = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_ST1  = 4'd1,
      PH_ST2  = 4'd2,
      PH_SP1  = 4'd3,
      PH_SP2  = 4'd4,
      PH_WR_A = 4'd5,
      PH_WR_B = 4'd6,
      PH_WR_C = 4'd7,
      PH_RD_A = 4'd8,
      PH_RD_B = 4'd9,
      PH_AK_A = 4'd10,
      PH_AK_B = 4'd11,
      PH_WA_A = 4'd12,
      PH_WA_B = 4'd13,
      PH_WA_P = 4'd14
   } phase_type;

   localparam logic CSR_TICKS_PER_US = 1'b0;
   localparam logic CSR_ACK_LIMIT    = 1'b1;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_timeout;
   } rsp_type;

endpackage
`default_nettype wire

// File: src/i2cm_seq.sv
// Phase sequencer: pin state, delay counter and byte shifter, one item per step.
`default_nettype none
module i2cm_seq
   import i2cm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [2:0]         op,
   input  wire logic [7:0]         data_byte,
   input  wire logic               ack_after_read,
   input  wire logic               sda_sample,
   input  wire logic [TPU_W-1:0]   ticks_per_us,
   input  wire logic [LIMIT_W-1:0] ack_timeout_limit,
   output rsp_type                 result
);

   phase_type          phase_ff, phase_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [7:0]         shift_ff, shift_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [7:0]         wait_ff, wait_in;
   logic               ackc_ff, ackc_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic               drv_ff, drv_in;
   logic [7:0]         last_ff, last_in;
   logic               tmo_ff, tmo_in;

   logic               is_tick, is_cmd, poll, elapsed, byte_end, wa_fail, done;
   logic [BIT_W-1:0]   bit_next;
   logic [7:0]         shift_wr;
   logic [DELAY_W-1:0] dly4, dly2, dly1, delay_dec;

   assign dly4 = {1'b0, ticks_per_us, 2'b00};
   assign dly2 = {2'b00, ticks_per_us, 1'b0};
   assign dly1 = {3'b000, ticks_per_us};

   assign is_tick   = step && (op == OP_TICK) && (phase_ff != PH_IDLE);
   assign is_cmd    = step && (phase_ff == PH_IDLE) && (op != OP_TICK) && (op <= OP_WAIT_ACK);
   assign poll      = (phase_ff == PH_WA_P);
   assign elapsed   = (delay_ff <= DELAY_W'(1));
   assign delay_dec = elapsed ? '0 : delay_ff - DELAY_W'(1);
   assign bit_next  = bit_ff + BIT_W'(1);
   assign byte_end  = (bit_next >= BIT_W'(BITS_PER_BYTE));
   assign wa_fail   = (wait_ff >= ack_timeout_limit);
   assign shift_wr  = {shift_ff[6:0], 1'b0};

   assign done = is_tick &&
                 ((poll && !sda_sample) ||
                  (!poll && elapsed &&
                   ((phase_ff == PH_ST2) || (phase_ff == PH_SP2) ||
                    (phase_ff == PH_AK_B) || ((phase_ff == PH_WR_C) && byte_end))));

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (is_cmd) begin
         unique case (op)
            OP_START: phase_in = PH_ST1;
            OP_STOP:  phase_in = PH_SP1;
            OP_WRITE: phase_in = PH_WR_A;
            OP_READ:  phase_in = PH_RD_A;
            default:  phase_in = PH_WA_A;
         endcase
      end else if (done) begin
         phase_in = PH_IDLE;
      end else if (is_tick && poll) begin
         if (sda_sample && wa_fail) begin
            phase_in = PH_SP1;
         end
      end else if (is_tick && elapsed) begin
         unique case (phase_ff)
            PH_ST1:  phase_in = PH_ST2;
            PH_SP1:  phase_in = PH_SP2;
            PH_WR_A: phase_in = PH_WR_B;
            PH_WR_B: phase_in = PH_WR_C;
            PH_WR_C: phase_in = PH_WR_A;
            PH_RD_A: phase_in = PH_RD_B;
            PH_RD_B: phase_in = byte_end ? PH_AK_A : PH_RD_A;
            PH_AK_A: phase_in = PH_AK_B;
            PH_WA_A: phase_in = PH_WA_B;
            PH_WA_B: phase_in = PH_WA_P;
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Pins, delay counter and datapath.
   always_comb begin
      cmd_in   = cmd_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      delay_in = delay_ff;
      wait_in  = wait_ff;
      ackc_in  = ackc_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      drv_in   = drv_ff;
      last_in  = last_ff;
      tmo_in   = tmo_ff;
      if (is_cmd) begin
         cmd_in  = op;
         tmo_in  = 1'b0;
         bit_in  = '0;
         wait_in = '0;
         unique case (op)
            OP_START: begin
               drv_in   = 1'b1;
               sda_in   = 1'b1;
               scl_in   = 1'b1;
               delay_in = dly4;
            end
            OP_STOP: begin
               drv_in   = 1'b1;
               scl_in   = 1'b0;
               sda_in   = 1'b0;
               delay_in = dly4;
            end
            OP_WRITE: begin
               shift_in = data_byte;
               drv_in   = 1'b1;
               scl_in   = 1'b0;
               sda_in   = data_byte[7];
               delay_in = dly2;
            end
            OP_READ: begin
               shift_in = '0;
               ackc_in  = ack_after_read;
               drv_in   = 1'b0;
               scl_in   = 1'b0;
               delay_in = dly2;
            end
            default: begin
               drv_in   = 1'b0;
               sda_in   = 1'b1;
               delay_in = dly1;
            end
         endcase
      end else if (is_tick && poll) begin
         if (!sda_sample) begin
            scl_in = 1'b0;
         end else if (wa_fail) begin
            // give up: force a stop sequence
            drv_in   = 1'b1;
            scl_in   = 1'b0;
            sda_in   = 1'b0;
            delay_in = dly4;
         end else begin
            wait_in = wait_ff + 8'd1;
         end
      end else if (is_tick) begin
         delay_in = delay_dec;
         if (elapsed) begin
            case (phase_ff)
               PH_ST1: begin
                  sda_in   = 1'b0;
                  delay_in = dly4;
               end
               PH_ST2: scl_in = 1'b0;
               PH_SP1: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  delay_in = dly4;
               end
               PH_SP2: begin
                  if (cmd_ff == OP_WAIT_ACK) begin
                     tmo_in = 1'b1;
                  end
               end
               PH_WR_A: begin
                  scl_in   = 1'b1;
                  delay_in = dly2;
               end
               PH_WR_B: begin
                  scl_in   = 1'b0;
                  delay_in = dly2;
               end
               PH_WR_C: begin
                  shift_in = shift_wr;
                  bit_in   = bit_next;
                  if (!byte_end) begin
                     sda_in   = shift_wr[7];
                     delay_in = dly2;
                  end
               end
               PH_RD_A: begin
                  scl_in   = 1'b1;
                  shift_in = {shift_ff[6:0], sda_sample};
                  delay_in = dly1;
               end
               PH_RD_B: begin
                  bit_in   = bit_next;
                  scl_in   = 1'b0;
                  delay_in = dly2;
                  if (byte_end) begin
                     drv_in = 1'b1;
                     sda_in = !ackc_ff;
                  end
               end
               PH_AK_A: begin
                  scl_in   = 1'b1;
                  delay_in = dly2;
               end
               PH_AK_B: begin
                  scl_in  = 1'b0;
                  last_in = shift_ff;
               end
               PH_WA_A: begin
                  scl_in   = 1'b1;
                  delay_in = dly1;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cmd_ff   <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         delay_ff <= '0;
         wait_ff  <= '0;
         ackc_ff  <= 1'b0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         drv_ff   <= 1'b0;
         last_ff  <= '0;
         tmo_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         delay_ff <= delay_in;
         wait_ff  <= wait_in;
         ackc_ff  <= ackc_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         drv_ff   <= drv_in;
         last_ff  <= last_in;
         tmo_ff   <= tmo_in;
      end
   end

   always_comb begin
      result.scl_level   = scl_in;
      result.sda_level   = sda_in;
      result.sda_drive   = drv_in;
      result.busy_res    = (phase_in != PH_IDLE);
      result.done_res    = done;
      result.read_data   = last_in;
      result.ack_timeout = tmo_in;
   end

   a_idle_delay_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (delay_ff == '0))
      else $error("delay counter not cleared while idle");

   a_bit_index_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= BIT_W'(BITS_PER_BYTE))
      else $error("bit index past end of byte");

   a_read_releases_sda: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_RD_A) || (phase_ff == PH_RD_B)) |-> !drv_ff)
      else $error("SDA driven during read bit");

   a_write_drives_sda: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_WR_A) || (phase_ff == PH_WR_B) || (phase_ff == PH_WR_C)) |-> drv_ff)
      else $error("SDA released during write bit");

endmodule
`default_nettype wire

// File: src/i2c_master_bit_sequencer.sv
// I2C master bit sequencer top level: item register, sequencer, result register.
//
// Usage: each request beat is either a timebase tick (op tick, carrying the
// sampled SDA level) or a command (start, stop, write byte, read byte, wait
// for ack). Every request beat yields exactly one response beat with the pin
// levels after the item, busy/done flags, the last read byte and the ack
// timeout flag. A command that arrives while a command is running is ignored.
// Delay phases last 4, 2 or 1 units of ticks_per_us tick beats.
// An accepted request beat loads the item register; while the response
// side is not stalled, the item then moves through the sequencer into the
// result register. Throughput is one item per cycle while the response is
// not stalled; the phase logic between the two registers is combinational.
// When the receiver stalls, the response holds and the item register still
// takes one more request beat; further requests are stalled.
// The configuration port is always ready; write it only while the block is
// idle. Synchronous reset returns the pins to SCL high, SDA high and
// released, sets ticks_per_us to 1 and ack_timeout_limit to 250.
`default_nettype none
module i2c_master_bit_sequencer
   import i2cm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [2:0]          req_op,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic                req_ack_after_read,
   input  wire logic                req_sda_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_scl_level,
   output logic                     rsp_sda_level,
   output logic                     rsp_sda_drive,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic [7:0]               rsp_read_data,
   output logic                     rsp_ack_timeout,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic                csr_index,
   input  wire logic [TPU_W-1:0]    csr_wdata
);

   logic               in_valid_ff, in_valid_in;
   logic [2:0]         op_ff;
   logic [7:0]         data_ff;
   logic               ack_ff;
   logic               sda_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, result;
   logic [TPU_W-1:0]   tpu_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               out_blocked, advance, req_accept;

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign advance     = in_valid_ff && !out_blocked;
   assign req_stall   = in_valid_ff && out_blocked;
   assign req_accept  = req_valid && !req_stall;
   assign csr_ready   = 1'b1;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : out_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tpu_ff       <= TPU_W'(1);
         limit_ff     <= LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TICKS_PER_US: tpu_ff   <= csr_wdata;
               CSR_ACK_LIMIT:    limit_ff <= csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Item and result payload: no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_op;
         data_ff <= req_data_byte;
         ack_ff  <= req_ack_after_read;
         sda_ff  <= req_sda_sample;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   i2cm_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .step              (advance),
      .op                (op_ff),
      .data_byte         (data_ff),
      .ack_after_read    (ack_ff),
      .sda_sample        (sda_ff),
      .ticks_per_us      (tpu_ff),
      .ack_timeout_limit (limit_ff),
      .result            (result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_level   = rsp_ff.scl_level;
   assign rsp_sda_level   = rsp_ff.sda_level;
   assign rsp_sda_drive   = rsp_ff.sda_drive;
   assign rsp_busy_res    = rsp_ff.busy_res;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_read_data   = rsp_ff.read_data;
   assign rsp_ack_timeout = rsp_ff.ack_timeout;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.done_res) |-> !rsp_ff.busy_res)
      else $error("response both done and busy");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_blocked) |=> in_valid_ff)
      else $error("item dropped while response stalled");

   a_result_beat: assert property (@(posedge clock) disable iff (reset)
      $past(advance) |-> rsp_valid_ff)
      else $error("processed item produced no response");

endmodule
`default_nettype wire
